FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-gated property checks used by the queue top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define FQID_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that an antecedent implies a consequent in the following cycle
`define FQID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/fqid_pkg.sv
// ----------------------------------------------------------------------------
// fqid_pkg
// Types and constants for the queue with indexed discard.
// ----------------------------------------------------------------------------
package fqid_pkg;

	localparam int DEPTH      = 16;
	localparam int ELEM_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int POS_W      = 4;

	typedef enum logic [1:0] {
		FUNC_ENQUEUE = 2'd0,
		FUNC_DEQUEUE = 2'd1,
		FUNC_DISCARD = 2'd2,
		FUNC_NOP     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2,
		ERR_RANGE = 2'd3
	} err_t;

	typedef struct packed {
		func_t                         func;
		logic signed [ELEM_WIDTH-1:0] elem_in;
		logic [POS_W-1:0]              position;
	} cmd_t;

	typedef struct packed {
		logic signed [ELEM_WIDTH-1:0] head_elem;
		logic [CNT_W-1:0]              count;
		logic                          is_empty;
		err_t                          error;
	} rsp_t;

	// Per-cell control from the controller
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

	// Controller status toward the top level
	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] count;
		err_t             error;
	} ctrl_stat_t;

endpackage

FILE: rtl/core/fifo_queue_with_indexed_discard.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_indexed_discard
// Bounded FIFO of signed elements with enqueue, dequeue and discard at a
// position from the head, built as a row of shift cells.
//
//   Port    Dir  Handshake              Content
//   cmd     in   start high, busy low   func, elem_in, position
//   rsp     out  done strobe, 1 cycle   head_elem, count, is_empty, error
//
// One transaction per cycle: the result appears the cycle after start.
// Enqueue loads the tail cell; a removal shifts every cell at or above the
// removed slot down by one in the same cycle. busy is held low.
// Reset empties the queue (fill count zero); cell contents are not cleared.
// The receiver cannot stall: done lasts exactly one cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fifo_queue_with_indexed_discard import fqid_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output rsp_t rsp
);

	cell_ctrl_t [DEPTH-1:0]               ctl;
	ctrl_stat_t                           stat;
	logic signed [DEPTH-1:0][ELEM_WIDTH-1:0] elems;
	logic                                 acc;

	assign busy = 1'b0;
	assign acc  = start && !busy;

	fqid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.cmd    (cmd),
		.ctl    (ctl),
		.stat   (stat)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		// Last cell has no upper neighbor: hold its own element
		fqid_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.elem_in   (cmd.elem_in),
			.next_elem ((i == DEPTH - 1) ? elems[i] : elems[(i + 1) % DEPTH]),
			.elem      (elems[i])
		);
	end

	assign done          = stat.done;
	assign rsp.count     = stat.count;
	assign rsp.is_empty  = (stat.count == '0);
	assign rsp.head_elem = (stat.count == '0) ? '0 : elems[0];
	assign rsp.error     = stat.error;

	`FQID_ASSERT_NEXT(a_done_follows_start, clk, arst_n, acc, done,
		"result strobe missing after accepted transaction")
	`FQID_ASSERT(a_count_bound, clk, arst_n, stat.count <= CNT_W'(DEPTH),
		"fill count exceeds depth")
	`FQID_ASSERT(a_full_refusal, clk, arst_n,
		(done && rsp.error == ERR_FULL) |-> (rsp.count == CNT_W'(DEPTH)),
		"full refusal reported while queue not full")
	`FQID_ASSERT(a_empty_refusal, clk, arst_n,
		(done && rsp.error == ERR_EMPTY) |-> rsp.is_empty,
		"empty refusal reported while queue holds elements")

endmodule

FILE: rtl/core/fqid_cell.sv
// ----------------------------------------------------------------------------
// fqid_cell
// One storage slot of the shift-cell queue: load from the tail or take the
// neighbor's element when a gap closes.
// ----------------------------------------------------------------------------
module fqid_cell import fqid_pkg::*; (
	input  logic                          clk,
	input  cell_ctrl_t                    ctl,
	input  logic signed [ELEM_WIDTH-1:0] elem_in,
	input  logic signed [ELEM_WIDTH-1:0] next_elem,
	output logic signed [ELEM_WIDTH-1:0] elem
);

	logic signed [ELEM_WIDTH-1:0] elem_q;

	// Hold the element unless the cell shifts or loads
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			elem_q <= next_elem;
		end else if (ctl.load) begin
			elem_q <= elem_in;
		end
	end

	assign elem = elem_q;

endmodule

FILE: rtl/core/fqid_ctrl.sv
// ----------------------------------------------------------------------------
// fqid_ctrl
// Fill count, operation decode, refusal checks and per-cell load/shift
// enables for the shift-cell queue.
// ----------------------------------------------------------------------------
module fqid_ctrl import fqid_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   acc,
	input  cmd_t                   cmd,
	output cell_ctrl_t [DEPTH-1:0] ctl,
	output ctrl_stat_t             stat
);

	logic [CNT_W-1:0] count_q;
	err_t             err_q;
	logic             done_q;

	err_t             err;
	logic             enq_ok;
	logic             rm_ok;
	logic [CNT_W-1:0] rm_pos;
	logic [CNT_W-1:0] pos_ext;
	logic [CNT_W-1:0] count_nxt;

	assign pos_ext = CNT_W'(cmd.position);

	always_comb begin
		err    = ERR_NONE;
		enq_ok = 1'b0;
		rm_ok  = 1'b0;
		rm_pos = '0;
		unique case (cmd.func)
			FUNC_ENQUEUE: begin
				if (count_q >= CNT_W'(DEPTH)) begin
					err = ERR_FULL;
				end else begin
					enq_ok = 1'b1;
				end
			end
			FUNC_DEQUEUE: begin
				if (count_q == '0) begin
					err = ERR_EMPTY;
				end else begin
					rm_ok = 1'b1;
				end
			end
			FUNC_DISCARD: begin
				if (count_q == '0) begin
					err = ERR_EMPTY;
				end else if (pos_ext >= count_q) begin
					err = ERR_RANGE;
				end else begin
					rm_ok  = 1'b1;
					rm_pos = pos_ext;
				end
			end
			FUNC_NOP: begin
			end
			default: begin
			end
		endcase
	end

	// Shift every cell at or above the removed slot; load the tail slot
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ctl[i].shift = acc && rm_ok && (CNT_W'(i) >= rm_pos);
			ctl[i].load  = acc && enq_ok && (CNT_W'(i) == count_q);
		end
	end

	always_comb begin
		count_nxt = count_q;
		if (acc && enq_ok) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (acc && rm_ok) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= ERR_NONE;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= acc;
			if (acc) begin
				err_q <= err;
			end
		end
	end

	assign stat.done  = done_q;
	assign stat.count = count_q;
	assign stat.error = err_q;

endmodule
